/* design/wgbi_pkg.sv */
// ----------------------------------------------------------------------------
// wgbi_pkg: shared types and constants for the grid bilinear interpolator
// Widths, pixel classes and register indexes.
// ----------------------------------------------------------------------------
package wgbi_pkg;

  localparam int unsigned WindowDef   = 3;
  localparam int unsigned GridRowsDef = 1024;
  localparam int unsigned GridColsDef = 1024;

  localparam int unsigned ValW   = 16;
  localparam int unsigned PosW   = 12;
  localparam int unsigned GIdxW  = 10;
  localparam int unsigned ClassW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegMedian  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLines   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSamples = 2'd2;

  localparam logic [ClassW-1:0] ClsCentre = 3'd0;
  localparam logic [ClassW-1:0] ClsFill   = 3'd1;
  localparam logic [ClassW-1:0] ClsCloud  = 3'd2;
  localparam logic [ClassW-1:0] ClsShadow = 3'd3;
  localparam logic [ClassW-1:0] ClsWater  = 3'd4;
  localparam logic [ClassW-1:0] ClsInterp = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [PosW-1:0]   line;
    logic [PosW-1:0]   sample;
    logic [GIdxW-1:0]  grid_row;
    logic [GIdxW-1:0]  grid_col;
    logic [ValW-1:0]   center_value;
    logic              center_water;
    logic              is_fill;
    logic              has_cloud;
    logic              has_shadow;
    logic              is_water;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0]   aero_value;
    logic [ClassW-1:0] pixel_class;
    logic              water_mixed;
  } out_item_t;

endpackage

/* design/wgbi_if.sv */
// ----------------------------------------------------------------------------
// wgbi_in_if / wgbi_out_if: valid-ready channels
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wgbi_in_if import wgbi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wgbi_out_if import wgbi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/window_grid_bilinear_interp.sv */
// ----------------------------------------------------------------------------
// window_grid_bilinear_interp: pixel value from a coarse grid of centres
// Grid store in one synchronous memory, one entry read per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)   : load beats (mode 0) fill the grid store, pixel beats
//                     (mode 1) yield one result each. Load beats yield none.
//   out_if (source) : one result beat per pixel beat, held in an output
//                     register until taken.
//   cfg_we_i/cfg_idx_i/cfg_data_i: register writes, only while idle.
// Timing: a load beat is written to the grid store as it is taken. An
//   interpolated pixel walks a sequencer: a decode state, then per neighbour
//   entry a read, a weight product and an accumulate state, then finish and
//   output states. Fill, cloud/shadow/water and kept-centre pixels skip the
//   neighbour walk. The next beat is taken only after the result is registered.
// A new beat is taken whenever the sequencer is idle, even with a result
//   still waiting, so the receiver may stall while the next pixel computes;
//   only a full output register with a finished next result waits on it.
// Reset: control state and registers return to defaults; the grid store is
//   not cleared, an unloaded entry reads as anything.
// ----------------------------------------------------------------------------
module window_grid_bilinear_interp
  import wgbi_pkg::*;
#(
  parameter int unsigned WINDOW    = WindowDef,
  parameter int unsigned GRID_ROWS = GridRowsDef,
  parameter int unsigned GRID_COLS = GridColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wgbi_in_if.sink             in_if,
  wgbi_out_if.source          out_if
);

  localparam int unsigned RowW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned ColW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned AddrW = RowW + ColW;
  localparam int unsigned HalfWin = WINDOW / 2;
  // gr/gc span: 3071/3 needs up to 10 bits; GW keeps PosW bits for any WINDOW
  localparam int unsigned GW = PosW;
  // reciprocal for /WINDOW on 12-bit values: exact for x < 4096
  localparam int unsigned RecSh = 24;
  localparam int unsigned Recip = ((1 << RecSh) + WINDOW - 1) / WINDOW;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StAddr  = 7'b0000010,
    StRead  = 7'b0000100,
    StMul1  = 7'b0001000,
    StMul2  = 7'b0010000,
    StDone  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ValW-1:0] median_q;
  logic [PosW-1:0] lines_q, samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_q  <= '0;
      lines_q   <= PosW'(3072);
      samples_q <= PosW'(3072);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMedian:  median_q  <= cfg_data_i;
        RegLines:   lines_q   <= cfg_data_i[PosW-1:0];
        RegSamples: samples_q <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- grid store ----------------
  // row-major, each row padded to a power of two columns
  logic [ValW:0]      mem [GRID_ROWS * (1 << ColW)];
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic [ValW:0]      mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem[mem_raddr];
  end

  // ---------------- input decode (registered pixel) ----------------
  in_item_t        pix_q;
  logic            in_fire;
  assign in_fire = in_if.valid && in_if.ready;

  // division of coordinates by WINDOW via reciprocal
  function automatic logic [GW-1:0] div_win(input logic [PosW-1:0] x);
    logic [PosW+RecSh:0] p;
    p = (PosW+RecSh+1)'(x) * (PosW+RecSh+1)'(Recip);
    return GW'(p >> RecSh);
  endfunction

  // weight: round(d*65536/WINDOW), d < WINDOW, small constant table
  function automatic logic [ValW:0] frac_w(input logic [PosW-1:0] d);
    logic [ValW:0] w;
    w = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (d == PosW'(k)) w = (ValW+1)'(((k << 16) + HalfWin) / WINDOW);
    end
    return w;
  endfunction

  logic [GW-1:0]   gr_q, gc_q;
  logic [PosW+1:0] cl_w, cs_w;
  logic            centre;
  logic [GW-1:0]   nr, nc;
  logic [RowW-1:0] r0, r1;
  logic [ColW-1:0] c0, c1;
  logic [PosW-1:0] dl, ds;

  assign cl_w = (PosW+2)'(gr_q) * (PosW+2)'(WINDOW) + (PosW+2)'(HalfWin);
  assign cs_w = (PosW+2)'(gc_q) * (PosW+2)'(WINDOW) + (PosW+2)'(HalfWin);
  assign centre = ((PosW+2)'(pix_q.line) == cl_w) && ((PosW+2)'(pix_q.sample) == cs_w);

  always_comb begin
    if ((PosW+2)'(pix_q.line) < cl_w) nr = (gr_q == '0) ? gr_q : gr_q - 1'b1;
    else if ((PosW+3)'(cl_w) + (PosW+3)'(WINDOW) + (PosW+3)'(1) >= (PosW+3)'(lines_q))
      nr = gr_q;
    else nr = gr_q + 1'b1;
    if ((PosW+2)'(pix_q.sample) < cs_w) nc = (gc_q == '0) ? gc_q : gc_q - 1'b1;
    else if ((PosW+3)'(cs_w) + (PosW+3)'(WINDOW) + (PosW+3)'(1) >= (PosW+3)'(samples_q))
      nc = gc_q;
    else nc = gc_q + 1'b1;
  end

  function automatic logic [RowW-1:0] sat_r(input logic [GW-1:0] i);
    return (32'(i) >= GRID_ROWS) ? RowW'(GRID_ROWS - 1) : RowW'(i);
  endfunction
  function automatic logic [ColW-1:0] sat_c(input logic [GW-1:0] i);
    return (32'(i) >= GRID_COLS) ? ColW'(GRID_COLS - 1) : ColW'(i);
  endfunction

  assign r0 = sat_r(gr_q);
  assign c0 = sat_c(gc_q);
  assign r1 = sat_r(nr);
  assign c1 = sat_c(nc);
  assign dl = PosW'(((PosW+2)'(pix_q.line) >= cl_w) ? (PosW+2)'(pix_q.line) - cl_w
                                                     : cl_w - (PosW+2)'(pix_q.line));
  assign ds = PosW'(((PosW+2)'(pix_q.sample) >= cs_w) ? (PosW+2)'(pix_q.sample) - cs_w
                                                       : cs_w - (PosW+2)'(pix_q.sample));

  // ---------------- sequencer ----------------
  logic [1:0]   k_q, k_d;          // neighbour index
  logic [16:0]  u_q, v_q;
  logic [33:0]  wprod_q;           // Q2.32 weight, up to 2^32
  logic [49:0]  acc_q, acc_d;
  logic         wmix_q;
  logic [ValW:0] ent_q;
  out_item_t    res_q;
  logic         res_v_q;
  logic         gq_ok;
  logic         is_q;

  assign gq_ok = (32'(gr_q) < GRID_ROWS) && (32'(gc_q) < GRID_COLS);
  assign is_q = pix_q.has_cloud || pix_q.has_shadow || pix_q.is_water;

  logic [ClassW-1:0] qcls;
  assign qcls = pix_q.has_cloud ? ClsCloud : (pix_q.has_shadow ? ClsShadow : ClsWater);

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;

  always_comb begin
    mem_raddr = {r0, c0};
    case (k_q)
      2'd0: mem_raddr = {r0, c0};
      2'd1: mem_raddr = {r0, c1};
      2'd2: mem_raddr = {r1, c0};
      default: mem_raddr = {r1, c1};
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {RowW'(in_if.data.grid_row), ColW'(in_if.data.grid_col)};
    mem_wdata = {in_if.data.center_water, in_if.data.center_value};
    if (in_fire && !in_if.data.mode &&
        (32'(in_if.data.grid_row) < GRID_ROWS) && (32'(in_if.data.grid_col) < GRID_COLS))
      mem_we = 1'b1;
    else if (state_q == StAddr && !pix_q.is_fill && is_q && centre && gq_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {r0, c0};
      mem_wdata = {pix_q.is_water && !pix_q.has_cloud && !pix_q.has_shadow, median_q};
    end
  end

  logic [16:0] wr, wc;
  always_comb begin
    wr = k_q[1] ? u_q : 17'h10000 - u_q;
    wc = k_q[0] ? v_q : 17'h10000 - v_q;
  end

  logic [33:0] wprod_d;
  assign wprod_d = 34'(wr) * 34'(wc);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    acc_d   = acc_q;
    case (state_q)
      StIdle: if (in_fire && in_if.data.mode) state_d = StAddr;
      StAddr: begin
        if (pix_q.is_fill || is_q || centre) state_d = StDone;
        else begin
          state_d = StRead;
          k_d = 2'd0;
          acc_d = '0;
        end
      end
      StRead: state_d = StMul1;                // memory latency
      StMul1: state_d = StMul2;                // weight product
      StMul2: begin                            // accumulate w*a
        acc_d = acc_q + 50'(wprod_q) * 50'(ent_q[ValW-1:0]);
        if (k_q == 2'd3) state_d = StDone;
        else begin
          k_d = k_q + 1'b1;
          state_d = StRead;
        end
      end
      StDone: state_d = StOut;
      StOut: if (!res_v_q || out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // centre read needs memory data: StDone issues at read address k=0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= (state_q == StAddr) ? 2'd0 : k_d;
      if (out_if.valid && out_if.ready) res_v_q <= 1'b0;
      if (state_q == StOut && (!res_v_q || out_if.ready)) res_v_q <= 1'b1;
    end
  end

  logic [16:0] val_r;
  always_comb begin
    val_r = 17'((acc_q + 50'h80000000) >> 32);
  end

  out_item_t res_d;
  always_comb begin
    res_d = '0;
    if (pix_q.is_fill) res_d.pixel_class = ClsFill;
    else if (is_q) begin
      res_d.pixel_class = qcls;
      res_d.aero_value  = median_q;
    end else if (centre) begin
      res_d.pixel_class = ClsCentre;
      res_d.aero_value  = mem_rdata_q[ValW-1:0];
    end else begin
      res_d.pixel_class = ClsInterp;
      res_d.aero_value  = val_r[16] ? 16'hFFFF : val_r[ValW-1:0];
      res_d.water_mixed = wmix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.data.mode) begin
      pix_q <= in_if.data;
      gr_q  <= div_win(in_if.data.line);
      gc_q  <= div_win(in_if.data.sample);
    end
    if (state_q == StAddr) begin
      u_q    <= frac_w(dl);
      v_q    <= frac_w(ds);
      wmix_q <= 1'b0;
    end
    if (state_q == StMul1) begin
      ent_q   <= mem_rdata_q;
      wprod_q <= wprod_d;
      wmix_q  <= wmix_q | mem_rdata_q[ValW];
    end
    acc_q <= acc_d;
    if (state_q == StOut && (!res_v_q || out_if.ready)) res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !out_if.ready) |=> res_v_q) else $error("result dropped");
  a_pix_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> (state_q == StOut)) else $error("sequencer slip");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAddr) |=> (k_q == 2'd0)) else $error("neighbour index not reset");
`endif

endmodule
